>>> sv/apr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants of the affine point and ray transform unit.
// ----------------------------------------------------------------------------
package apr_pkg;

  // default fraction bits of the coordinate format
  localparam int COORD_FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;

  localparam logic [CFG_W-1:0] TRANS_RST = 48'h0000_0000_0000;
  localparam logic [CFG_W-1:0] ROT_RST   = 48'h0000_0000_0000;
  localparam logic [CFG_W-1:0] SCALE_RST = 48'h0100_0100_0100;

  // matrix coefficients are Q16.16
  localparam int COEF_W = 32;
  localparam int R_W    = 20;   // rotation entries, magnitude below 2^18
  localparam int S_W    = 16;   // Q8.8 scale factor

  typedef logic [8:0][COEF_W-1:0] mat3_t;

  localparam mat3_t MAT_IDENT = {32'h0001_0000, 32'h0, 32'h0,
                                 32'h0, 32'h0001_0000, 32'h0,
                                 32'h0, 32'h0, 32'h0001_0000};

  // matrix builder to datapath
  typedef struct packed {
    mat3_t            fwd;
    mat3_t            inv;
    mat3_t            nrm;
    logic [2:0][15:0] trans;
    logic             busy;
  } mtx_t;

  // one lane's row result
  typedef struct packed {
    logic [31:0] point;
    logic [31:0] dir;
    logic        sat;
  } lane_res_t;

  // rebuild sequencer
  typedef enum logic [2:0] {
    MX_IDLE,
    MX_TRIG,
    MX_ROT,
    MX_FWD,
    MX_NRM
  } mx_state_t;

endpackage
`default_nettype wire

>>> sv/affine_point_ray_transform_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_point_ray_transform_unit
// Translate / rotate / scale transform of points, rays and normals.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : one word per item; tuser carries the command, tdata the point
//          and the direction. out_* : transformed point and direction, tuser
//          flags a clamped component.
//  cfg_* : writes translation, rotation or scale. Each write starts a matrix
//          rebuild (sine polynomial and rotation on one shared multiplier,
//          then nine serial divisions); in_tready stays low until it ends.
//          A new write restarts it.
//  Throughput is one word per cycle unless out_tready stalls or a rebuild
//  runs: three row lanes work in parallel, each with its own six multipliers.
//  Reset loads the identity transform and leaves the block ready.
//  A stall on out_tready freezes the pipeline and drops in_tready; the
//  output register holds its word until it is taken.
// ----------------------------------------------------------------------------
module affine_point_ray_transform_unit
  import apr_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // point_x, point_y, point_z, dir_x, dir_y, dir_z
  input  wire logic [191:0]         in_tdata,
  // cmd
  input  wire logic [1:0]           in_tuser,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // out_point_x, out_point_y, out_point_z, out_dir_x, out_dir_y, out_dir_z
  output logic [191:0]              out_tdata,
  // saturated
  output logic [0:0]                out_tuser,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  mtx_t            mtx;
  lane_res_t       lres [3];
  logic            en;
  logic            v1_r, v2_r, out_valid_r;
  logic [191:0]    out_data_r;
  logic            out_sat_r;
  logic [2:0][33:0] tc;
  logic [63:0]     tcf [3];

  apr_mtx u_mtx (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mtx       (mtx)
  );

  // translation in the coordinate format
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tcf[j] = 64'($signed(mtx.trans[j])) <<< (8 + COORD_FRAC_BITS);
      tc[j]  = 34'($signed(tcf[j]) >>> 16);
    end
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && !mtx.busy;

  // row lanes
  for (genvar i = 0; i < 3; i++) begin : g_lane
    apr_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane (
      .clk     (clk),
      .en      (en),
      .cmd     (in_tuser),
      .pnt     (in_tdata[95:0]),
      .dir     (in_tdata[191:96]),
      .tc      (tc),
      .fwd_row (mtx.fwd[i*3 +: 3]),
      .inv_row (mtx.inv[i*3 +: 3]),
      .nrm_row (mtx.nrm[i*3 +: 3]),
      .t_i     (mtx.trans[i]),
      .res     (lres[i])
    );
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_tvalid && in_tready;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // merge lanes into the output word
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {lres[2].dir, lres[1].dir, lres[0].dir,
                     lres[2].point, lres[1].point, lres[0].point};
      out_sat_r  <= lres[0].sat | lres[1].sat | lres[2].sat;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

`ifndef ASSERT_OFF
  a_rebuild_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(mtx.busy) |-> $past(cfg_we))
    else $error("rebuild started without a register write");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    mtx.busy |-> !in_tready)
    else $error("input open during matrix rebuild");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted word lost at first stage");

  a_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && en |=> out_valid_r)
    else $error("word lost before output register");
`endif

endmodule
`default_nettype wire

>>> sv/apr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apr_div
// Radix-2 restoring divider: round(num * 256 / den), ties away from zero.
// ----------------------------------------------------------------------------
module apr_div
  import apr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic signed [R_W-1:0] num,
  input  wire logic [S_W-1:0]        den,
  output logic                       done,
  output logic [COEF_W-1:0]          quo
);

  localparam int DW  = R_W + 8;
  localparam int CW  = $clog2(DW + 1);

  logic [DW-1:0]  dvd_r;
  logic [S_W-1:0] rem_r;
  logic [S_W-1:0] den_r;
  logic [CW-1:0]  cnt_r;
  logic           neg_r;
  logic           done_r;

  logic [R_W-1:0] mag;
  logic [S_W:0]   rem_sh;
  logic           qbit;
  logic [S_W-1:0] rem_nxt;

  // magnitude of the numerator
  assign mag = num[R_W-1] ? R_W'(-num) : R_W'(num);

  // one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DW-1]};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_nxt = qbit ? S_W'(rem_sh - {1'b0, den_r}) : S_W'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1));
      if (start) begin
        cnt_r <= CW'(DW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= DW'({mag, 8'h00}) + DW'(den >> 1);
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[R_W-1];
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DW-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -COEF_W'(dvd_r) : COEF_W'(dvd_r);

endmodule
`default_nettype wire

>>> sv/apr_mtx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apr_mtx
// Configuration registers and matrix rebuild sequencer (one shared
// multiplier, one divider): sines, rotation, forward, normal and inverse.
// ----------------------------------------------------------------------------
module apr_mtx
  import apr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output mtx_t                      mtx
);

  // polynomial coefficients of the quarter-wave sine
  localparam logic signed [69:0] QA1 = 70'sd1686629713;
  localparam logic signed [69:0] QA3 = 70'sd693598667;
  localparam logic signed [69:0] QA5 = 70'sd85569278;
  localparam logic signed [69:0] QA7 = 70'sd5027005;
  localparam logic signed [31:0] QA9 = 32'sd172276;

  localparam logic signed [69:0] HALF8  = 70'sd128;
  localparam logic signed [69:0] HALF16 = 70'sd32768;
  localparam logic signed [69:0] HALF30 = 70'sd536870912;
  localparam logic signed [69:0] HALF32 = 70'sd2147483648;
  localparam logic signed [69:0] ONE16  = 70'sd65536;

  // sine substeps
  localparam logic [2:0] TS_SQ = 3'd0;
  localparam logic [2:0] TS_H9 = 3'd1;
  localparam logic [2:0] TS_H7 = 3'd2;
  localparam logic [2:0] TS_H5 = 3'd3;
  localparam logic [2:0] TS_H3 = 3'd4;
  localparam logic [2:0] TS_FN = 3'd5;

  // rotation steps
  localparam logic [3:0] RS_R00  = 4'd0;
  localparam logic [3:0] RS_R10  = 4'd1;
  localparam logic [3:0] RS_R21  = 4'd2;
  localparam logic [3:0] RS_R22  = 4'd3;
  localparam logic [3:0] RS_R20  = 4'd4;
  localparam logic [3:0] RS_CZSY = 4'd5;
  localparam logic [3:0] RS_SZSY = 4'd6;
  localparam logic [3:0] RS_U01  = 4'd7;
  localparam logic [3:0] RS_R01  = 4'd8;
  localparam logic [3:0] RS_U02  = 4'd9;
  localparam logic [3:0] RS_R02  = 4'd10;
  localparam logic [3:0] RS_U11  = 4'd11;
  localparam logic [3:0] RS_R11  = 4'd12;
  localparam logic [3:0] RS_U12  = 4'd13;
  localparam logic [3:0] RS_R12  = 4'd14;

  // trig slots
  localparam int SX = 0, CX = 1, SY = 2, CY = 3, SZ = 4, CZ = 5;

  logic [CFG_W-1:0] trans_r, rot_r, scale_r;
  mx_state_t        state_r, state_nxt;
  logic [3:0]       cnt_r;
  logic [2:0]       sub_r;
  logic [1:0]       row_r, col_r;
  logic             launched_r;
  logic [16:0]      x2_r;
  logic signed [31:0]    p_r;
  logic signed [17:0]    trig_r [6];
  logic signed [R_W-1:0] rm_r [9];
  logic signed [33:0]    czsy_r, szsy_r, u_r;
  mat3_t            fwd_r, inv_r, nrm_r;

  logic             cfg_hit;
  logic [1:0]       axis;
  logic [15:0]      ang;
  logic [14:0]      rr;
  logic [16:0]      xq;
  logic [3:0]       idx, tidx;
  logic [S_W-1:0]   s_col, s_eff;
  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [67:0] prod;
  logic signed [69:0] pe, ush, res, fin;
  logic             last_ent;
  logic             div_start, div_done;
  logic [COEF_W-1:0] div_q;

  assign cfg_hit = cfg_we && (cfg_index == REG_TRANS || cfg_index == REG_ROT ||
                              cfg_index == REG_SCALE);

  // angle for the current sine slot; odd slots are cosines
  always_comb begin
    axis = cnt_r[2:1];
    ang  = rot_r[{axis, 4'b0000} +: 16] + (cnt_r[0] ? 16'h4000 : 16'h0000);
    rr   = ang[14] ? 15'(15'h4000 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    xq   = {rr, 2'b00};
  end

  // matrix entry addressing
  always_comb begin
    idx      = 4'({row_r, 1'b0}) + 4'(row_r) + 4'(col_r);
    tidx     = 4'({col_r, 1'b0}) + 4'(col_r) + 4'(row_r);
    s_col    = scale_r[{col_r, 4'b0000} +: 16];
    s_eff    = (s_col == '0) ? S_W'(1) : s_col;
    last_ent = (row_r == 2'd2) && (col_r == 2'd2);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_hit) begin
      state_nxt = MX_TRIG;
    end else begin
      unique case (state_r)
        MX_IDLE: state_nxt = MX_IDLE;
        MX_TRIG: if (sub_r == TS_FN && cnt_r == 4'd5) state_nxt = MX_ROT;
        MX_ROT:  if (cnt_r == RS_R12) state_nxt = MX_FWD;
        MX_FWD:  if (last_ent) state_nxt = MX_NRM;
        MX_NRM:  if (launched_r && div_done && last_ent) state_nxt = MX_IDLE;
        default: state_nxt = MX_IDLE;
      endcase
    end
  end

  // multiplier operands and divider launch
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      MX_TRIG: begin
        unique case (sub_r)
          TS_SQ:   begin mul_a = 36'(xq);   mul_b = 32'(xq); end
          TS_H9:   begin mul_a = 36'(x2_r); mul_b = QA9;     end
          TS_FN:   begin mul_a = 36'(xq);   mul_b = p_r;     end
          default: begin mul_a = 36'(x2_r); mul_b = p_r;     end
        endcase
      end
      MX_ROT: begin
        unique case (cnt_r)
          RS_R00:  begin mul_a = 36'(trig_r[CZ]); mul_b = 32'(trig_r[CY]); end
          RS_R10:  begin mul_a = 36'(trig_r[SZ]); mul_b = 32'(trig_r[CY]); end
          RS_R21:  begin mul_a = 36'(trig_r[CY]); mul_b = 32'(trig_r[SX]); end
          RS_R22:  begin mul_a = 36'(trig_r[CY]); mul_b = 32'(trig_r[CX]); end
          RS_CZSY: begin mul_a = 36'(trig_r[CZ]); mul_b = 32'(trig_r[SY]); end
          RS_SZSY: begin mul_a = 36'(trig_r[SZ]); mul_b = 32'(trig_r[SY]); end
          RS_U01:  begin mul_a = 36'(trig_r[SZ]); mul_b = 32'(trig_r[CX]); end
          RS_R01:  begin mul_a = 36'(czsy_r);     mul_b = 32'(trig_r[SX]); end
          RS_U02:  begin mul_a = 36'(trig_r[SZ]); mul_b = 32'(trig_r[SX]); end
          RS_R02:  begin mul_a = 36'(czsy_r);     mul_b = 32'(trig_r[CX]); end
          RS_U11:  begin mul_a = 36'(trig_r[CZ]); mul_b = 32'(trig_r[CX]); end
          RS_R11:  begin mul_a = 36'(szsy_r);     mul_b = 32'(trig_r[SX]); end
          RS_U12:  begin mul_a = 36'(trig_r[CZ]); mul_b = 32'(trig_r[SX]); end
          RS_R12:  begin mul_a = 36'(szsy_r);     mul_b = 32'(trig_r[CX]); end
          default: begin mul_a = '0;              mul_b = '0;              end
        endcase
      end
      MX_FWD: begin
        mul_a = 36'(rm_r[idx]);
        mul_b = 32'(s_eff);
      end
      MX_NRM:  div_start = !launched_r;
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign pe   = 70'(prod);
  assign ush  = 70'(u_r) <<< 16;
  assign fin  = (pe + HALF30) >>> 30;

  // post-multiply add and rounding
  always_comb begin
    res = '0;
    unique case (state_r)
      MX_TRIG: begin
        unique case (sub_r)
          TS_SQ:   res = (pe + HALF16) >>> 16;
          TS_H9:   res = QA7 - (pe >>> 16);
          TS_H7:   res = QA5 - (pe >>> 16);
          TS_H5:   res = QA3 - (pe >>> 16);
          TS_H3:   res = QA1 - (pe >>> 16);
          default: begin
            res = (fin > ONE16) ? ONE16 : fin;
            if (ang[15]) res = -res;
          end
        endcase
      end
      MX_ROT: begin
        unique case (cnt_r)
          RS_R00, RS_R10, RS_R21, RS_R22: res = (pe + HALF16) >>> 16;
          RS_R20:  res = -70'(trig_r[SY]);
          RS_R01, RS_R12: res = (pe - ush + HALF32) >>> 32;
          RS_R02, RS_R11: res = (pe + ush + HALF32) >>> 32;
          default: res = pe;
        endcase
      end
      MX_FWD:  res = (pe + HALF8) >>> 8;
      default: res = '0;
    endcase
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= MX_IDLE;
      trans_r    <= TRANS_RST;
      rot_r      <= ROT_RST;
      scale_r    <= SCALE_RST;
      cnt_r      <= '0;
      sub_r      <= '0;
      row_r      <= '0;
      col_r      <= '0;
      launched_r <= 1'b0;
      fwd_r      <= MAT_IDENT;
      inv_r      <= MAT_IDENT;
      nrm_r      <= MAT_IDENT;
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        unique case (cfg_index)
          REG_TRANS: trans_r <= cfg_data;
          REG_ROT:   rot_r   <= cfg_data;
          default:   scale_r <= cfg_data;
        endcase
        cnt_r      <= '0;
        sub_r      <= '0;
        row_r      <= '0;
        col_r      <= '0;
        launched_r <= 1'b0;
      end else begin
        unique case (state_r)
          MX_TRIG: begin
            if (sub_r == TS_FN) begin
              sub_r <= '0;
              cnt_r <= (cnt_r == 4'd5) ? 4'd0 : cnt_r + 4'd1;
            end else begin
              sub_r <= sub_r + 3'd1;
            end
          end
          MX_ROT: cnt_r <= (cnt_r == RS_R12) ? 4'd0 : cnt_r + 4'd1;
          MX_FWD: begin
            fwd_r[idx] <= COEF_W'(res);
            col_r      <= (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
            if (col_r == 2'd2) row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
          end
          MX_NRM: begin
            if (!launched_r) begin
              launched_r <= 1'b1;
            end else if (div_done) begin
              // inverse rotation part is the transpose of the normal matrix
              nrm_r[idx]  <= div_q;
              inv_r[tidx] <= div_q;
              launched_r  <= 1'b0;
              col_r       <= (col_r == 2'd2) ? 2'd0 : col_r + 2'd1;
              if (col_r == 2'd2) row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // working registers of the sine and rotation steps
  always_ff @(posedge clk) begin
    if (state_r == MX_TRIG) begin
      unique case (sub_r)
        TS_SQ:   x2_r <= 17'(res);
        TS_FN:   trig_r[cnt_r[2:0]] <= 18'(res);
        default: p_r <= 32'(res);
      endcase
    end
    if (state_r == MX_ROT) begin
      unique case (cnt_r)
        RS_R00:  rm_r[0] <= R_W'(res);
        RS_R10:  rm_r[3] <= R_W'(res);
        RS_R21:  rm_r[7] <= R_W'(res);
        RS_R22:  rm_r[8] <= R_W'(res);
        RS_R20:  rm_r[6] <= R_W'(res);
        RS_CZSY: czsy_r  <= 34'(res);
        RS_SZSY: szsy_r  <= 34'(res);
        RS_R01:  rm_r[1] <= R_W'(res);
        RS_R02:  rm_r[2] <= R_W'(res);
        RS_R11:  rm_r[4] <= R_W'(res);
        RS_R12:  rm_r[5] <= R_W'(res);
        default: u_r     <= 34'(res);
      endcase
    end
  end

  apr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rm_r[idx]),
    .den   (s_eff),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    mtx.fwd   = fwd_r;
    mtx.inv   = inv_r;
    mtx.nrm   = nrm_r;
    mtx.trans = trans_r;
    mtx.busy  = (state_r != MX_IDLE);
  end

endmodule
`default_nettype wire

>>> sv/apr_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apr_lane
// One output row: operand select, six products, sum, round and clamp.
// ----------------------------------------------------------------------------
module apr_lane
  import apr_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [1:0]             cmd,
  input  wire logic [2:0][31:0]       pnt,
  input  wire logic [2:0][31:0]       dir,
  input  wire logic [2:0][33:0]       tc,
  input  wire logic [2:0][COEF_W-1:0] fwd_row,
  input  wire logic [2:0][COEF_W-1:0] inv_row,
  input  wire logic [2:0][COEF_W-1:0] nrm_row,
  input  wire logic [15:0]            t_i,
  output lane_res_t                   res
);

  localparam int OFFW = 24 + COORD_FRAC_BITS;
  localparam int SUMW = 70;
  localparam logic signed [SUMW-1:0] HALF16 = 70'sd32768;
  localparam logic signed [SUMW-1:0] MAXV   = 70'sd2147483647;
  localparam logic signed [SUMW-1:0] MINV   = -70'sd2147483648;

  logic signed [33:0]       x_r  [3];
  logic signed [31:0]       a_r  [3];
  logic signed [31:0]       b_r  [3];
  logic signed [31:0]       d_r  [3];
  logic signed [OFFW-1:0]   off_r, off2_r;
  logic                     dsel_r, dsel2_r;
  logic signed [65:0]       pp_r [3];
  logic signed [63:0]       dp_r [3];

  logic signed [SUMW-1:0]   sp, sd, rp, rd;

  // stage 1: pick matrix row and offset by command
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        x_r[j] <= cmd[1] ? 34'($signed(pnt[j]))
                         : 34'($signed(pnt[j])) - $signed(tc[j]);
        a_r[j] <= cmd[1] ? $signed(fwd_row[j]) : $signed(inv_row[j]);
        b_r[j] <= cmd[1] ? $signed(nrm_row[j]) : $signed(inv_row[j]);
        d_r[j] <= $signed(dir[j]);
      end
      off_r  <= cmd[1] ? (OFFW'($signed(t_i)) <<< (8 + COORD_FRAC_BITS)) : '0;
      dsel_r <= cmd[0];
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pp_r[j] <= a_r[j] * x_r[j];
        dp_r[j] <= b_r[j] * d_r[j];
      end
      off2_r  <= off_r;
      dsel2_r <= dsel_r;
    end
  end

  // sum, round half up, clamp
  always_comb begin
    sp = SUMW'(pp_r[0]) + SUMW'(pp_r[1]) + SUMW'(pp_r[2]) + SUMW'(off2_r);
    sd = SUMW'(dp_r[0]) + SUMW'(dp_r[1]) + SUMW'(dp_r[2]);
    rp = (sp + HALF16) >>> 16;
    rd = (sd + HALF16) >>> 16;
    res.sat   = 1'b0;
    res.point = rp[31:0];
    res.dir   = '0;
    if (rp > MAXV) begin
      res.point = 32'h7FFF_FFFF;
      res.sat   = 1'b1;
    end else if (rp < MINV) begin
      res.point = 32'h8000_0000;
      res.sat   = 1'b1;
    end
    if (dsel2_r) begin
      res.dir = rd[31:0];
      if (rd > MAXV) begin
        res.dir = 32'h7FFF_FFFF;
        res.sat = 1'b1;
      end else if (rd < MINV) begin
        res.dir = 32'h8000_0000;
        res.sat = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
